// ===== hdl/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

  // ascii anchors of the base64 alphabet
  localparam logic [7:0] UpperOffset = 8'd65;  // 'A' for sextet 0
  localparam logic [7:0] LowerOffset = 8'd71;  // 'a' minus 26
  localparam logic [7:0] DigitBias   = 8'd4;   // '0' is sextet 52 minus 4
  localparam logic [7:0] PlusChar    = 8'd43;  // '+'
  localparam logic [7:0] SlashChar   = 8'd47;  // '/'
  localparam logic [7:0] PadChar     = 8'd61;  // '='

  localparam logic [5:0] LowerStart  = 6'd26;
  localparam logic [5:0] DigitStart  = 6'd52;
  localparam logic [5:0] PlusCode    = 6'd62;

  // position of the next byte within a three byte group
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  // characters produced by one input byte, emitted in order chars[0]..chars[last_idx]
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } b64e_job_t;

  // queue status seen by the back end
  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < LowerStart) begin
      return w + UpperOffset;
    end else if (s < DigitStart) begin
      return w + LowerOffset;
    end else if (s < PlusCode) begin
      return w - DigitBias;
    end else if (s == PlusCode) begin
      return PlusChar;
    end else begin
      return SlashChar;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64e_if.sv =====
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_text;

  modport source(output valid, output out_char, output end_of_text, input ready);
  modport sink(input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/base64_stream_encoder_unit.sv =====
`default_nettype none

// channel    dir  payload                         meaning
// data_in    in   data_byte[7:0], final_byte      raw byte, marks last byte of message
// char_out   out  out_char[7:0], end_of_text      base64 char or '=', marks last char
//
// front end maps each byte to 1..4 characters in the cycle it is taken
// back end sends one character per cycle while char_out.ready stays high, so a steady stream
// gives four characters per three bytes; the output register sets that pace
// a byte is taken whenever the job queue has room, even while the output is stalled
// synchronous active-high rst clears group phase, carry bits, queue and output valid

module base64_stream_encoder_unit
  import b64e_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  b64e_in_if.sink   data_in,
  b64e_out_if.source char_out
);

  localparam int CntW = $clog2(QueueDepth + 1);

  // front to queue
  logic      push;
  b64e_job_t push_job;

  // queue to back
  b64e_job_t       head_job;
  q_stat_t         stat;
  logic [CntW-1:0] count;
  logic            pop;

  // classify the byte, keep group phase and leftover bits
  b64e_front u_front (
    .clk     (clk),
    .rst     (rst),
    .data_in (data_in),
    .full    (stat.full),
    .push    (push),
    .job     (push_job)
  );

  // short queue lets the input keep going while characters drain
  b64e_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat),
    .count    (count)
  );

  // serialize the characters of each job through the output register
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .stat     (stat),
    .pop      (pop),
    .char_out (char_out)
  );

  // back end only retires a job that is really there
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.head_valid)
    else $error("job popped from empty queue");

  // an accepted byte always leaves a job waiting in the queue
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (data_in.valid && data_in.ready) |=> (count != '0))
    else $error("accepted byte produced no queued job");

  // occupancy stays within the queue
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== hdl/b64e_front.sv =====
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  b64e_in_if.sink    data_in,
  input  wire logic  full,
  output logic       push,
  output b64e_job_t  job
);

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;
  logic [7:0] b;
  logic       fin;

  assign b             = data_in.data_byte;
  assign fin           = data_in.final_byte;
  assign data_in.ready = !full;
  assign push          = data_in.valid && !full;

  always_comb begin
    job.chars    = '0;
    job.last_idx = 2'd0;
    job.fin      = fin;
    phase_next   = phase;
    carry_next   = carry;
    unique case (phase)
      PH_SECOND: begin
        job.chars[0] = sextet_char({carry[1:0], b[7:4]});
        if (fin) begin
          job.chars[1] = sextet_char({b[3:0], 2'b00});
          job.chars[2] = PadChar;
          job.last_idx = 2'd2;
        end else begin
          carry_next = b[3:0];
          phase_next = PH_THIRD;
        end
      end
      PH_THIRD: begin
        job.chars[0] = sextet_char({carry, b[7:6]});
        job.chars[1] = sextet_char(b[5:0]);
        job.last_idx = 2'd1;
        carry_next   = 4'd0;
        phase_next   = PH_FIRST;
      end
      default: begin
        job.chars[0] = sextet_char(b[7:2]);
        if (fin) begin
          job.chars[1] = sextet_char({b[1:0], 4'b0000});
          job.chars[2] = PadChar;
          job.chars[3] = PadChar;
          job.last_idx = 2'd3;
        end else begin
          carry_next = {2'b00, b[1:0]};
          phase_next = PH_SECOND;
        end
      end
    endcase
    if (fin) begin
      carry_next = 4'd0;
      phase_next = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      carry <= 4'd0;
    end else if (push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_queue.sv =====
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire b64e_job_t                       push_job,
  input  wire logic                            pop,
  output b64e_job_t                            head_job,
  output q_stat_t                              stat,
  output logic [$clog2(QueueDepth + 1) - 1:0]  count
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  b64e_job_t slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  assign head_job        = slots[rd_ptr];
  assign stat.head_valid = count != '0;
  assign stat.full       = count == CntW'(QueueDepth);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_back.sv =====
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire b64e_job_t  head_job,
  input  wire q_stat_t    stat,
  output logic            pop,
  b64e_out_if.source      char_out
);

  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_eot;
  logic       load;
  logic       at_last;

  assign at_last = idx == head_job.last_idx;
  assign load    = stat.head_valid && (!out_valid || char_out.ready);
  assign pop     = load && at_last;

  assign char_out.valid       = out_valid;
  assign char_out.out_char    = out_char;
  assign char_out.end_of_text = out_eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? 2'd0 : idx + 2'd1;
    end else if (char_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head_job.chars[idx];
      out_eot  <= head_job.fin && at_last;
    end
  end

endmodule

`default_nettype wire
